// File: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Request and status codes, field widths and the cell control bundle shared
// by the double-ended queue and its storage cells.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int FIELD_WIDTH = 32;
  localparam int REQ_WIDTH   = 3;
  localparam int STAT_WIDTH  = 2;

  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_QUERY      = 3'd4
  } req_t;

  typedef enum logic [STAT_WIDTH-1:0] {
    STAT_DONE       = 2'd0,
    STAT_PUSH_FULL  = 2'd1,
    STAT_POP_EMPTY  = 2'd2
  } stat_t;

  typedef struct packed {
    logic take_left;
    logic take_right;
    logic load;
  } cell_ctl_t;

endpackage

// File: hw/rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage position of the queue. Takes its left neighbor on a push at the
// front, its right neighbor on a pop at the front, or the new word on a push
// at the back when it is the first free position.
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] load_data,
  output logic [DATA_WIDTH-1:0] data
);

  always_ff @(posedge clk) begin
    priority if (ctl.take_left) begin
      data <= left_data;
    end else if (ctl.take_right) begin
      data <= right_data;
    end else if (ctl.load) begin
      data <= load_data;
    end else begin
      data <= data;
    end
  end

endmodule

// File: hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words held in a row of cells, front at cell 0.
// Every request answers with the front and back words, flags, count and status.
//
//   channel   signals                                        handshake
//   request   req_type, push_value                           start / busy
//   result    front_value, back_value, is_empty, is_full,    done
//             entry_total, status
//
// One request per cycle unless busy; its result is shown in the cycle after the
// accepting edge, for that cycle only, while the next request may already be
// taken. The cell row shifts at that edge, so no request waits on another.
// busy is set in reset and cleared by any edge without it; reset empties the
// queue without touching cell contents. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32,
  localparam int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [REQ_WIDTH-1:0]   req_type,
  input  logic [FIELD_WIDTH-1:0] push_value,
  output logic                   done,
  output logic [FIELD_WIDTH-1:0] front_value,
  output logic [FIELD_WIDTH-1:0] back_value,
  output logic                   is_empty,
  output logic                   is_full,
  output logic [CW-1:0]          entry_total,
  output logic [STAT_WIDTH-1:0]  status
);

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  stat_t                 stat;
  stat_t                 stat_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  do_push_front;
  logic                  do_push_back;
  logic                  do_pop_front;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  logic [DATA_WIDTH-1:0] back_raw;
  logic [FIELD_WIDTH-1:0] front_ext;
  logic [FIELD_WIDTH-1:0] back_ext;
  cell_ctl_t             ctl [CAPACITY];

  assign accept = start && !busy;
  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);

  // request decode
  always_comb begin
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    stat_next     = STAT_DONE;
    count_next    = count;
    if (accept) begin
      unique case (req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (full) begin
            stat_next = STAT_PUSH_FULL;
          end else begin
            do_push_front = (req_type == REQ_PUSH_FRONT);
            do_push_back  = (req_type == REQ_PUSH_BACK);
            count_next    = count + CW'(1);
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (empty) begin
            stat_next = STAT_POP_EMPTY;
          end else begin
            do_pop_front = (req_type == REQ_POP_FRONT);
            count_next   = count - CW'(1);
          end
        end
        default: begin
          stat_next = STAT_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      busy  <= 1'b1;
    end else begin
      count <= count_next;
      done  <= accept;
      busy  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat <= stat_next;
    end
  end

  // width adaption between the 32-bit fields and the stored words
  generate
    if (DATA_WIDTH == FIELD_WIDTH) begin : g_same
      assign push_word = push_value;
      assign front_ext = cell_q[0];
      assign back_ext  = back_raw;
    end else if (DATA_WIDTH > FIELD_WIDTH) begin : g_wide
      assign push_word = {{(DATA_WIDTH - FIELD_WIDTH){push_value[FIELD_WIDTH-1]}},
                          push_value};
      assign front_ext = cell_q[0][FIELD_WIDTH-1:0];
      assign back_ext  = back_raw[FIELD_WIDTH-1:0];
    end else begin : g_narrow
      assign push_word = push_value[DATA_WIDTH-1:0];
      assign front_ext = {{(FIELD_WIDTH - DATA_WIDTH){cell_q[0][DATA_WIDTH-1]}},
                          cell_q[0]};
      assign back_ext  = {{(FIELD_WIDTH - DATA_WIDTH){back_raw[DATA_WIDTH-1]}},
                          back_raw};
    end
  endgenerate

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = push_word;
    end else begin : g_mid_l
      assign left_data = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_q[i];
    end else begin : g_mid_r
      assign right_data = cell_q[i+1];
    end

    assign ctl[i].take_left  = do_push_front;
    assign ctl[i].take_right = do_pop_front;
    assign ctl[i].load       = do_push_back && (count == CW'(i));

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .left_data  (left_data),
      .right_data (right_data),
      .load_data  (push_word),
      .data       (cell_q[i])
    );
  end

  // back entry sits at the last occupied cell
  always_comb begin
    back_raw = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (count == CW'(i + 1)) begin
        back_raw = back_raw | cell_q[i];
      end
    end
  end

  assign front_value = empty ? '1 : front_ext;
  assign back_value  = empty ? '1 : back_ext;
  assign is_empty    = empty;
  assign is_full     = full;
  assign entry_total = count;
  assign status      = stat;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_BACK))
    |=> (status == STAT_PUSH_FULL && is_full))
    else $error("push on full queue not dropped");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (req_type == REQ_POP_FRONT || req_type == REQ_POP_BACK))
    |=> (status == STAT_POP_EMPTY && is_empty))
    else $error("pop on empty queue not ignored");

  a_push_front_seen: assert property (@(posedge clk) disable iff (rst)
    (accept && !full && req_type == REQ_PUSH_FRONT)
    |=> (cell_q[0] == $past(push_word)))
    else $error("front push not at cell 0");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the double-ended queue against a shadow deque kept in the bench.
// A short directed run hits the empty corners, every request code
// and the extreme words. It is followed by random requests in phases that
// favor balanced, push-heavy or pop-heavy traffic, with random idle gaps.
// Every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int TOTAL_W     = $clog2(DEPTH + 1);
  localparam int RAND_ITEMS  = 450;
  localparam int CYCLE_LIMIT = 40000;

  localparam logic [REQ_WIDTH-1:0] REQ_SPARE_5 = 3'd5;
  localparam logic [REQ_WIDTH-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_WIDTH-1:0] REQ_SPARE_7 = 3'd7;

  typedef struct {
    logic [FIELD_WIDTH-1:0] front;
    logic [FIELD_WIDTH-1:0] back;
    logic                   empty;
    logic                   full;
    logic [TOTAL_W-1:0]     total;
    stat_t                  stat;
  } deq_view_t;

  class deque_shadow;
    logic [FIELD_WIDTH-1:0] slots [DEPTH];
    int                     head;
    int                     count;
    deq_view_t              views_due [$];
    int                     errors;

    function new();
      head   = 0;
      count  = 0;
      errors = 0;
    endfunction

    task report(input string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task take_request(input logic [REQ_WIDTH-1:0] code,
                      input logic [FIELD_WIDTH-1:0] word);
      deq_view_t v;
      v.stat = STAT_DONE;
      case (code)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (count == DEPTH) begin
            v.stat = STAT_PUSH_FULL;
          end else if (code == REQ_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = word;
            count++;
          end else begin
            slots[(head + count) % DEPTH] = word;
            count++;
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (count == 0) begin
            v.stat = STAT_POP_EMPTY;
          end else begin
            if (code == REQ_POP_FRONT) head = (head + 1) % DEPTH;
            count--;
          end
        end
        default: ;
      endcase
      if (count == 0) begin
        v.front = '1;
        v.back  = '1;
      end else begin
        v.front = slots[head];
        v.back  = slots[(head + count - 1) % DEPTH];
      end
      v.empty = (count == 0);
      v.full  = (count == DEPTH);
      v.total = count[TOTAL_W-1:0];
      views_due.insert(views_due.size(), v);
    endtask

    task compare_view(input logic [FIELD_WIDTH-1:0] fv, input logic [FIELD_WIDTH-1:0] bv,
                      input logic em, input logic fu, input logic [TOTAL_W-1:0] tot,
                      input logic [STAT_WIDTH-1:0] st);
      deq_view_t v;
      if (views_due.size() == 0) begin
        report("result beat with no request outstanding");
      end else begin
        v = views_due[0];
        views_due.delete(0);
        if (fv !== v.front)
          report($sformatf("front_value %h, want %h", fv, v.front));
        if (bv !== v.back)
          report($sformatf("back_value %h, want %h", bv, v.back));
        if (em !== v.empty)
          report($sformatf("is_empty %b, want %b", em, v.empty));
        if (fu !== v.full)
          report($sformatf("is_full %b, want %b", fu, v.full));
        if (tot !== v.total)
          report($sformatf("entry_total %0d, want %0d", tot, v.total));
        if (st !== v.stat)
          report($sformatf("status %0d, want %0d", st, v.stat));
      end
    endtask

    function int pending();
      return views_due.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   start      = 1'b0;
  logic [REQ_WIDTH-1:0]   req_type   = '0;
  logic [FIELD_WIDTH-1:0] push_value = '0;
  logic                   busy;
  logic                   done;
  logic [FIELD_WIDTH-1:0] front_value;
  logic [FIELD_WIDTH-1:0] back_value;
  logic                   is_empty;
  logic                   is_full;
  logic [TOTAL_W-1:0]     entry_total;
  logic [STAT_WIDTH-1:0]  status;

  deque_shadow shadow = new();
  int          cycles = 0;

  double_ended_queue #(
    .CAPACITY   (DEPTH),
    .DATA_WIDTH (FIELD_WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .push_value  (push_value),
    .done        (done),
    .front_value (front_value),
    .back_value  (back_value),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .entry_total (entry_total),
    .status      (status)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  // result beat checked before the request beat of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        shadow.compare_view(front_value, back_value, is_empty, is_full, entry_total, status);
      if (start && !busy)
        shadow.take_request(req_type, push_value);
    end
  end

  task idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task send_req(input logic [REQ_WIDTH-1:0] code, input logic [FIELD_WIDTH-1:0] word);
    @(negedge clk);
    start      <= 1'b1;
    req_type   <= code;
    push_value <= word;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
  endtask

  task maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(0, 99) < 37) idle_cycles(1);
  endtask

  function logic [FIELD_WIDTH-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      4:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function logic [REQ_WIDTH-1:0] pick_code(input int phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      case ($urandom_range(0, 2))
        0:       return REQ_SPARE_5;
        1:       return REQ_SPARE_6;
        default: return REQ_SPARE_7;
      endcase
    end
    roll = $urandom_range(0, 99);
    case (phase)
      1: begin
        if (roll < 80) return roll[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        if (roll < 95) return roll[0] ? REQ_POP_FRONT : REQ_POP_BACK;
        return REQ_QUERY;
      end
      2: begin
        if (roll < 20) return roll[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        if (roll < 95) return roll[0] ? REQ_POP_FRONT : REQ_POP_BACK;
        return REQ_QUERY;
      end
      default: begin
        if (roll < 50) return roll[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
        if (roll < 90) return roll[0] ? REQ_POP_FRONT : REQ_POP_BACK;
        return REQ_QUERY;
      end
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty corners, extreme words, every code
    send_req(REQ_QUERY, '0);
    send_req(REQ_POP_FRONT, '0);
    maybe_idle(1'b0);
    send_req(REQ_POP_BACK, '1);
    send_req(REQ_PUSH_FRONT, 32'h7fff_ffff);
    send_req(REQ_PUSH_BACK, 32'h8000_0000);
    maybe_idle(1'b0);
    send_req(REQ_PUSH_FRONT, '1);
    send_req(REQ_PUSH_BACK, '0);
    send_req(REQ_SPARE_5, 32'h1234_5678);
    send_req(REQ_SPARE_6, '1);
    send_req(REQ_SPARE_7, '0);
    maybe_idle(1'b0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_PUSH_BACK, 32'h5555_5555);
    send_req(REQ_PUSH_FRONT, 32'haaaa_aaaa);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_QUERY, '1);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) wait_drained();
      maybe_idle(i >= 150 && i < 250);
      send_req(pick_code((i / 40) % 3), pick_word());
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_cell.sv
hw/rtl/double_ended_queue.sv
test/tb_top.sv
